### hdl/sdf_pkg.sv
// sdf_pkg: shared types, constants and the place-value threshold table
// for the signed decimal formatter. No dependencies.
package sdf_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int VALUE_W     = 32;
    localparam int NUM_POS     = 10;
    localparam int THR_W       = 36;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_entry;

    // thr[p][d] = d * 10**p
    typedef logic [NUM_POS-1:0][9:0][THR_W-1:0] t_thr_tbl;

    function automatic t_thr_tbl build_thr();
        t_thr_tbl         tbl;
        logic [THR_W-1:0] pw;
        pw = THR_W'(1);
        for (int p = 0; p < NUM_POS; p++) begin
            for (int d = 0; d < 10; d++) begin
                tbl[p][d] = THR_W'(d) * pw;
            end
            pw = pw * THR_W'(10);
        end
        return tbl;
    endfunction

    localparam t_thr_tbl THR = build_thr();

endpackage

### hdl/sdf_front.sv
// sdf_front: input register; splits a signed value into sign and magnitude.
// Depends on sdf_pkg.
module sdf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_value,
    input  logic                 i_q_full,
    output logic                 o_push,
    output sdf_pkg::t_entry      o_entry
);

    logic            r_valid;
    sdf_pkg::t_entry r_entry;
    logic            take;

    assign o_push  = r_valid && !i_q_full;
    assign o_stall = r_valid && i_q_full;
    assign take    = i_valid && !o_stall;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_entry.neg <= i_value[31];
            r_entry.mag <= i_value[31] ? (32'd0 - 32'(i_value)) : 32'(i_value);
        end
    end

endmodule

### hdl/sdf_queue.sv
// sdf_queue: small register FIFO between front and back.
// Depends on sdf_pkg.
module sdf_queue #(
    parameter int DEPTH = sdf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sdf_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sdf_pkg::t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sdf_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### hdl/sdf_back.sv
// sdf_back: emits sign and decimal digits, one place value per cycle while the output is not stalled,
// by compare against d*10^p thresholds. Depends on sdf_pkg.
module sdf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_pop,
    input  sdf_pkg::t_entry i_entry,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_character,
    output logic            o_last
);

    logic        r_busy;
    logic        r_sign;
    logic        r_started;
    logic [3:0]  r_pos;
    logic [31:0] r_rem;
    logic        r_ov;
    logic [7:0]  r_char;
    logic        r_last;

    logic        n_busy;
    logic        n_sign;
    logic        n_started;
    logic [3:0]  n_pos;
    logic [31:0] n_rem;
    logic        n_ov;
    logic [7:0]  n_char;
    logic        n_last;

    logic [sdf_pkg::THR_W-1:0] rem_ext;
    logic [sdf_pkg::THR_W-1:0] diff;
    logic [3:0]                digit;
    logic                      advance;
    logic                      emit;

    assign o_pop       = !r_busy && i_valid;
    assign advance     = r_busy && (!r_ov || !i_stall);
    assign o_valid     = r_ov;
    assign o_character = r_char;
    assign o_last      = r_last;

    always_comb begin
        rem_ext = {{(sdf_pkg::THR_W-32){1'b0}}, r_rem};
        digit   = 4'd0;
        for (int d = 1; d < 10; d++) begin
            if (rem_ext >= sdf_pkg::THR[r_pos][d]) begin
                digit = 4'(d);
            end
        end
        diff = rem_ext - sdf_pkg::THR[r_pos][digit];
        emit = r_started || (digit != 4'd0) || (r_pos == 4'd0);
    end

    always_comb begin
        n_busy    = r_busy;
        n_sign    = r_sign;
        n_started = r_started;
        n_pos     = r_pos;
        n_rem     = r_rem;
        n_ov      = r_ov && i_stall;
        n_char    = r_char;
        n_last    = r_last;
        if (o_pop) begin
            n_busy    = 1'b1;
            n_sign    = i_entry.neg;
            n_started = 1'b0;
            n_pos     = 4'(sdf_pkg::NUM_POS - 1);
            n_rem     = i_entry.mag;
        end else if (advance) begin
            if (r_sign) begin
                n_sign = 1'b0;
                n_ov   = 1'b1;
                n_char = sdf_pkg::ASCII_MINUS;
                n_last = 1'b0;
            end else begin
                n_ov      = emit;
                n_char    = sdf_pkg::ASCII_ZERO + {4'd0, digit};
                n_last    = (r_pos == 4'd0);
                n_rem     = diff[31:0];
                n_started = r_started || (digit != 4'd0);
                if (r_pos == 4'd0) begin
                    n_busy = 1'b0;
                end else begin
                    n_pos = r_pos - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
        end
        r_sign    <= n_sign;
        r_started <= n_started;
        r_pos     <= n_pos;
        r_rem     <= n_rem;
        r_char    <= n_char;
        r_last    <= n_last;
    end

endmodule

### hdl/signed_decimal_formatter.sv
// signed_decimal_formatter: top level; front register, FIFO, digit emitter.
// Depends on sdf_pkg, sdf_front, sdf_queue, sdf_back.
//
//  channel | signals                                  | direction
//  in      | i_valid, o_stall, i_value[31:0]          | one number per transaction
//  out     | o_valid, i_stall, o_character[7:0], o_last| one character per transaction
//
// The back end loads a number, then emits the sign for a negative number and
// works through the ten place values in turn with the single digit-compare
// unit; it takes no new number until the last place value is done. Leading
// zeros take a step but produce no character. Reset is synchronous, active
// low, and empties the FIFO and output register. Output stall holds the
// emitter; input stall rises once the front register and FIFO are full.
module signed_decimal_formatter #(
    parameter int QUEUE_DEPTH = sdf_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_character,
    output logic               o_last
);

    sdf_pkg::t_entry front_entry;
    sdf_pkg::t_entry back_entry;
    logic            q_full;
    logic            q_push;
    logic            q_valid;
    logic            q_pop;

    sdf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (front_entry)
    );

    sdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (back_entry)
    );

    sdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_entry     (back_entry),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule
